FILE: sv/pmn_pkg.sv
package pmn_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_W,
    ST_DADR,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_SQRT_W,
    ST_MD,
    ST_MD_W,
    ST_NADR,
    ST_NDIV,
    ST_NDIV_W,
    ST_NOUT,
    ST_STAT
  } seq_state_t;

  // Shared unit operations
  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  // Result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_STATS = 1'b1;

endpackage

FILE: sv/point_match_normalizer.sv
// Point correspondence normalizer (per-image centering and scaling).
// Input: command style. A correspondence (two points, two sigmas, last flag)
// is taken on a clock edge with start high and busy low. Loading gives no
// result; items past MAX_POINTS are dropped, but their last flag still ends
// the run.
// After the last transaction busy stays high while one shared bit-serial
// divide/sqrt unit (AW = 68 bits with default widths) does the divides and roots:
//   means:      4 divides
//   distances:  per point 2 roots
//   mean dists: 2 divides
//   outputs:    per point up to 6 divides
// Results: out_strobe marks one transaction, high for exactly one cycle.
// Point transactions come in arrival order, then one stats transaction
// (means, mean distances, out_last_out set). The receiver cannot stall.
// Reset (rst_n low, synchronous) returns to idle and clears the count and
// running sums; the point store is not cleared.
module point_match_normalizer #(
  parameter int MAX_POINTS  = 32,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic        [COORD_WIDTH-2:0] in_first_sigma,
  input  logic        [COORD_WIDTH-2:0] in_second_sigma,
  input  logic                          in_last_in,
  output logic                          out_strobe,
  output logic                          out_kind,
  output logic signed [COORD_WIDTH-1:0] out_v0,
  output logic signed [COORD_WIDTH-1:0] out_v1,
  output logic signed [COORD_WIDTH-1:0] out_v2,
  output logic signed [COORD_WIDTH-1:0] out_v3,
  output logic signed [COORD_WIDTH-1:0] out_v4,
  output logic signed [COORD_WIDTH-1:0] out_v5,
  output logic                          out_last_out
);

  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW    = CW + CNT_W;        // coordinate sum
  localparam int CCW   = CW + 1;            // centered value
  localparam int RW    = 2 * CCW + 1;       // sum of squares
  localparam int RTW   = CCW + 1;           // root
  localparam int DW    = RTW + CNT_W;       // distance sum
  localparam int NW    = CCW + FRAC_BITS;   // scaled numerator
  localparam int AW0   = (SW > DW ? SW : DW) > (NW > RW ? NW : RW) ?
                         (SW > DW ? SW : DW) : (NW > RW ? NW : RW);
  localparam int AW    = AW0 + (AW0 % 2);
  localparam int MW    = 4 * CW + 2 * (CW - 1);

  localparam logic [AW-1:0] LIM_POS = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [AW-1:0] LIM_NEG = LIM_POS + AW'(1);
  localparam logic [DW-1:0] MD_MAX  = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};

  pmn_pkg::seq_state_t state_r, state_nxt;

  // point store: fx, fy, sx, sy, fsigma, ssigma
  logic [MW-1:0] mem [MAX_POINTS];
  logic [MW-1:0] rd_r;

  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     k_r;
  logic [2:0]           j_r;
  logic                 img_r;
  logic signed [SW-1:0] sum_r [4];
  logic [CW-1:0]        mean_r [4];
  logic [DW-1:0]        dsum_r [2];
  logic [DW-1:0]        md_r [2];
  logic [CW-1:0]        res_r [6];
  logic [2*CCW-1:0]     sq_r, acc_r;

  // shared unit
  logic               a_go, a_done;
  pmn_pkg::arith_op_t a_op;
  logic [AW-1:0]      a_num, a_den, a_res;

  pmn_arith #(.AW(AW)) u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (a_go),
    .op   (a_op),
    .num  (a_num),
    .den  (a_den),
    .done (a_done),
    .res  (a_res)
  );

  // read data fields
  logic signed [CW-1:0] rd_fx, rd_fy, rd_sx, rd_sy;
  logic [CW-2:0]        rd_fs, rd_ss;
  assign rd_fx = rd_r[MW-1       -: CW];
  assign rd_fy = rd_r[MW-1-CW    -: CW];
  assign rd_sx = rd_r[MW-1-2*CW  -: CW];
  assign rd_sy = rd_r[MW-1-3*CW  -: CW];
  assign rd_fs = rd_r[2*CW-3     -: CW-1];
  assign rd_ss = rd_r[CW-2:0];

  logic signed [CCW-1:0] c_fx, c_fy, c_sx, c_sy;
  assign c_fx = CCW'(rd_fx) - CCW'($signed(mean_r[0]));
  assign c_fy = CCW'(rd_fy) - CCW'($signed(mean_r[1]));
  assign c_sx = CCW'(rd_sx) - CCW'($signed(mean_r[2]));
  assign c_sy = CCW'(rd_sy) - CCW'($signed(mean_r[3]));

  logic signed [CCW-1:0]   cx, cy;
  logic signed [2*CCW-1:0] sq;
  assign cx = img_r ? c_sx : c_fx;
  assign cy = img_r ? c_sy : c_fy;
  // one squarer; x in SQX, y in SQY
  assign sq = (state_r == pmn_pkg::ST_SQX) ? cx * cx : cy * cy;

  logic last_k;
  assign last_k = (CNT_W'(k_r) + CNT_W'(1)) == cnt_r;

  // normalize operand select
  logic signed [CCW-1:0] nv;
  logic                  nimg;
  always_comb begin
    case (j_r)
      3'd0:    begin nv = c_fx; nimg = 1'b0; end
      3'd1:    begin nv = c_fy; nimg = 1'b0; end
      3'd2:    begin nv = c_sx; nimg = 1'b1; end
      3'd3:    begin nv = c_sy; nimg = 1'b1; end
      3'd4:    begin nv = $signed({2'b00, rd_fs}); nimg = 1'b0; end
      default: begin nv = $signed({2'b00, rd_ss}); nimg = 1'b1; end
    endcase
  end

  logic          n_neg, md_zero;
  logic [CCW-1:0] n_mag;
  assign n_neg   = nv[CCW-1];
  assign n_mag   = n_neg ? (~nv + CCW'(1)) : nv;
  assign md_zero = (md_r[nimg] == '0);

  // mean operand
  logic          s_neg;
  logic [SW-1:0] s_mag;
  assign s_neg = sum_r[j_r[1:0]][SW-1];
  assign s_mag = s_neg ? (~sum_r[j_r[1:0]] + SW'(1)) : sum_r[j_r[1:0]];

  // result shaping
  logic [AW-1:0] q_sat;
  logic [CW-1:0] q_scaled, q_mean;
  assign q_sat    = (a_res > (n_neg ? LIM_NEG : LIM_POS)) ?
                    (n_neg ? LIM_NEG : LIM_POS) : a_res;
  assign q_scaled = n_neg ? (~q_sat[CW-1:0] + CW'(1)) : q_sat[CW-1:0];
  assign q_mean   = s_neg ? (~a_res[CW-1:0] + CW'(1)) : a_res[CW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmn_pkg::ST_IDLE:   if (start && in_last_in) state_nxt = pmn_pkg::ST_MEAN;
      pmn_pkg::ST_MEAN:   state_nxt = pmn_pkg::ST_MEAN_W;
      pmn_pkg::ST_MEAN_W: if (a_done) begin
        state_nxt = (j_r == 3'd3) ? pmn_pkg::ST_DADR : pmn_pkg::ST_MEAN;
      end
      pmn_pkg::ST_DADR:   state_nxt = pmn_pkg::ST_SQX;
      pmn_pkg::ST_SQX:    state_nxt = pmn_pkg::ST_SQY;
      pmn_pkg::ST_SQY:    state_nxt = pmn_pkg::ST_SQRT;
      pmn_pkg::ST_SQRT:   state_nxt = pmn_pkg::ST_SQRT_W;
      pmn_pkg::ST_SQRT_W: if (a_done) begin
        if (!img_r)      state_nxt = pmn_pkg::ST_SQX;
        else if (last_k) state_nxt = pmn_pkg::ST_MD;
        else             state_nxt = pmn_pkg::ST_DADR;
      end
      pmn_pkg::ST_MD:     state_nxt = pmn_pkg::ST_MD_W;
      pmn_pkg::ST_MD_W:   if (a_done) begin
        state_nxt = (j_r == 3'd1) ? pmn_pkg::ST_NADR : pmn_pkg::ST_MD;
      end
      pmn_pkg::ST_NADR:   state_nxt = pmn_pkg::ST_NDIV;
      pmn_pkg::ST_NDIV: begin
        if (!md_zero)          state_nxt = pmn_pkg::ST_NDIV_W;
        else if (j_r == 3'd5)  state_nxt = pmn_pkg::ST_NOUT;
      end
      pmn_pkg::ST_NDIV_W: if (a_done) begin
        state_nxt = (j_r == 3'd5) ? pmn_pkg::ST_NOUT : pmn_pkg::ST_NDIV;
      end
      pmn_pkg::ST_NOUT:   state_nxt = last_k ? pmn_pkg::ST_STAT : pmn_pkg::ST_NADR;
      pmn_pkg::ST_STAT:   state_nxt = pmn_pkg::ST_IDLE;
      default:            state_nxt = pmn_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: unit launch and operands
  always_comb begin
    a_go  = 1'b0;
    a_op  = pmn_pkg::OP_DIV;
    a_num = AW'(s_mag);
    a_den = AW'(cnt_r);
    busy  = (state_r != pmn_pkg::ST_IDLE);
    unique case (state_r)
      pmn_pkg::ST_MEAN: a_go = 1'b1;
      pmn_pkg::ST_SQRT: begin
        a_go  = 1'b1;
        a_op  = pmn_pkg::OP_SQRT;
        a_num = AW'({1'b0, acc_r} + {1'b0, sq_r});
      end
      pmn_pkg::ST_MD: begin
        a_go  = 1'b1;
        a_num = AW'(dsum_r[j_r[0]]);
      end
      pmn_pkg::ST_NDIV: begin
        a_go  = ~md_zero;
        a_num = AW'(n_mag) << FRAC_BITS;
        a_den = AW'(md_r[nimg]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pmn_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // point store
  always_ff @(posedge clk) begin
    if (state_r == pmn_pkg::ST_IDLE && start && cnt_r != CNT_W'(MAX_POINTS)) begin
      mem[cnt_r[IDX_W-1:0]] <= {in_first_x, in_first_y, in_second_x, in_second_y,
                                in_first_sigma, in_second_sigma};
    end
    rd_r <= mem[k_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      k_r        <= '0;
      j_r        <= '0;
      img_r      <= 1'b0;
      out_strobe <= 1'b0;
      for (int i = 0; i < 4; i++) sum_r[i] <= '0;
      dsum_r[0]  <= '0;
      dsum_r[1]  <= '0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        pmn_pkg::ST_IDLE: if (start) begin
          if (cnt_r != CNT_W'(MAX_POINTS)) begin
            sum_r[0] <= sum_r[0] + SW'(in_first_x);
            sum_r[1] <= sum_r[1] + SW'(in_first_y);
            sum_r[2] <= sum_r[2] + SW'(in_second_x);
            sum_r[3] <= sum_r[3] + SW'(in_second_y);
            cnt_r    <= cnt_r + CNT_W'(1);
          end
          j_r       <= '0;
          k_r       <= '0;
          img_r     <= 1'b0;
          dsum_r[0] <= '0;
          dsum_r[1] <= '0;
        end
        pmn_pkg::ST_MEAN_W: if (a_done) begin
          mean_r[j_r[1:0]] <= q_mean;
          j_r <= (j_r == 3'd3) ? 3'd0 : j_r + 3'd1;
        end
        pmn_pkg::ST_SQX: sq_r <= $unsigned(sq);
        pmn_pkg::ST_SQY: begin
          acc_r <= sq_r;
          sq_r  <= $unsigned(sq);
        end
        pmn_pkg::ST_SQRT_W: if (a_done) begin
          dsum_r[img_r] <= dsum_r[img_r] + DW'(a_res[RTW-1:0]);
          img_r <= ~img_r;
          if (img_r && !last_k) k_r <= k_r + IDX_W'(1);
        end
        pmn_pkg::ST_MD_W: if (a_done) begin
          md_r[j_r[0]] <= a_res[DW-1:0];
          j_r <= (j_r == 3'd1) ? 3'd0 : j_r + 3'd1;
          k_r <= '0;
        end
        pmn_pkg::ST_NDIV: if (md_zero) begin
          res_r[j_r] <= '0;
          j_r <= j_r + 3'd1;
        end
        pmn_pkg::ST_NDIV_W: if (a_done) begin
          res_r[j_r] <= q_scaled;
          j_r <= j_r + 3'd1;
        end
        pmn_pkg::ST_NOUT: begin
          out_strobe   <= 1'b1;
          out_kind     <= pmn_pkg::KIND_POINT;
          out_last_out <= 1'b0;
          out_v0 <= res_r[0];
          out_v1 <= res_r[1];
          out_v2 <= res_r[2];
          out_v3 <= res_r[3];
          out_v4 <= res_r[4];
          out_v5 <= res_r[5];
          j_r <= '0;
          if (!last_k) k_r <= k_r + IDX_W'(1);
        end
        pmn_pkg::ST_STAT: begin
          out_strobe   <= 1'b1;
          out_kind     <= pmn_pkg::KIND_STATS;
          out_last_out <= 1'b1;
          out_v0 <= mean_r[0];
          out_v1 <= mean_r[1];
          out_v2 <= mean_r[2];
          out_v3 <= mean_r[3];
          out_v4 <= (md_r[0] > MD_MAX) ? MD_MAX[CW-1:0] : md_r[0][CW-1:0];
          out_v5 <= (md_r[1] > MD_MAX) ? MD_MAX[CW-1:0] : md_r[1][CW-1:0];
          cnt_r  <= '0;
          for (int i = 0; i < 4; i++) sum_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/pmn_arith.sv
// Shared bit-serial unit: restoring divide (one quotient bit per cycle)
// or digit-by-digit square root (one root bit per cycle).
module pmn_arith #(
  parameter int AW = 68
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  pmn_pkg::arith_op_t op,
  input  logic [AW-1:0]      num,
  input  logic [AW-1:0]      den,
  output logic               done,
  output logic [AW-1:0]      res
);

  localparam int CTW = $clog2(AW + 1);

  pmn_pkg::arith_op_t op_r;
  logic [AW-1:0]  num_r, num_nxt;
  logic [AW-1:0]  den_r;
  logic [AW+1:0]  rem_r, rem_nxt;
  logic [AW-1:0]  q_r, q_nxt;
  logic [CTW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;

  logic [AW+1:0] shifted;
  logic [AW+1:0] trial;
  logic [AW+2:0] diff;
  logic          ge;

  always_comb begin
    if (op_r == pmn_pkg::OP_DIV) begin
      shifted = {rem_r[AW:0], num_r[AW-1]};
      trial   = {2'b00, den_r};
      num_nxt = {num_r[AW-2:0], 1'b0};
    end else begin
      shifted = {rem_r[AW-1:0], num_r[AW-1:AW-2]};
      trial   = {q_r, 2'b01};
      num_nxt = {num_r[AW-3:0], 2'b00};
    end
    diff    = {1'b0, shifted} - {1'b0, trial};
    ge      = ~diff[AW+2];
    rem_nxt = ge ? diff[AW+1:0] : shifted;
    q_nxt   = {q_r[AW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (go) begin
      op_r  <= op;
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= (op == pmn_pkg::OP_DIV) ? CTW'(AW) : CTW'(AW / 2);
    end else if (run_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - CTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CTW'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = q_r;

endmodule

FILE: sv/pmn_checker.sv
module pmn_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_in,
  input logic out_strobe,
  input logic out_kind,
  input logic out_last_out
);

  // reset leaves the block idle
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");

  // a last transaction starts processing
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_in |=> busy)
    else $error("last transaction did not start processing");

  // a plain transaction only loads
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_in |=> !busy)
    else $error("load transaction left block busy");

  // the run ends with the stats transaction
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_out |-> out_kind)
    else $error("last flag on a point transaction");

  // point transactions appear only while busy
  a_idle_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !busy |-> out_kind && out_last_out)
    else $error("point transaction while idle");

endmodule

bind point_match_normalizer pmn_checker u_pmn_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int MAXP        = 32;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_ITEMS  = 480;

  // One correspondence as driven on the input ports
  typedef struct {
    logic signed [31:0] fx, fy, sx, sy;
    logic        [30:0] s1, s2;
    logic               last;
  } corr_t;

  // One output transaction
  typedef struct {
    logic        kind;
    logic [31:0] v [6];
    logic        last;
  } norm_t;

  // Scoreboard: holds its own copy of the point store and running sums,
  // computes the whole normalized run when the last correspondence lands.
  class norm_scoreboard;
    corr_t       pts [MAXP];
    int          cnt;
    longint      csum [4];
    norm_t       pending [$];
    int          errors;

    function new();
      cnt = 0;
      errors = 0;
      foreach (csum[i]) csum[i] = 0;
    endfunction

    // floor(sqrt(v)) over 64 result bits
    function logic [63:0] isqrt(logic [127:0] v);
      logic [127:0] r, t;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= v) r = t;
      end
      return r[63:0];
    endfunction

    // (v << 16) / d, truncated toward zero, clipped to 32-bit signed
    function logic [31:0] scale_val(longint v, logic [63:0] d);
      logic          neg;
      logic [63:0]   m;
      logic [127:0]  q, lim;
      neg = v < 0;
      m   = neg ? 64'(-v) : 64'(v);
      q   = ({64'd0, m} << 16) / {64'd0, d};
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) q = lim;
      return neg ? 32'(-q) : 32'(q);
    endfunction

    function void note(corr_t c);
      longint      mean [4];
      longint      cx, cy, dx, dy;
      logic [63:0] dsum [2];
      logic [63:0] md [2];
      logic [63:0] ax, ay;
      norm_t       r;
      int          n;
      if (cnt < MAXP) begin
        pts[cnt] = c;
        csum[0] += longint'(c.fx);
        csum[1] += longint'(c.fy);
        csum[2] += longint'(c.sx);
        csum[3] += longint'(c.sy);
        cnt++;
      end
      if (!c.last) return;
      n = cnt;
      foreach (mean[i]) mean[i] = csum[i] / longint'(n);
      dsum[0] = 0;
      dsum[1] = 0;
      for (int k = 0; k < n; k++) begin
        cx = longint'(pts[k].fx) - mean[0];
        cy = longint'(pts[k].fy) - mean[1];
        ax = cx < 0 ? 64'(-cx) : 64'(cx);
        ay = cy < 0 ? 64'(-cy) : 64'(cy);
        dsum[0] += isqrt(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
        dx = longint'(pts[k].sx) - mean[2];
        dy = longint'(pts[k].sy) - mean[3];
        ax = dx < 0 ? 64'(-dx) : 64'(dx);
        ay = dy < 0 ? 64'(-dy) : 64'(dy);
        dsum[1] += isqrt(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
      end
      md[0] = dsum[0] / 64'(n);
      md[1] = dsum[1] / 64'(n);
      for (int k = 0; k < n; k++) begin
        r.kind = pmn_pkg::KIND_POINT;
        r.last = 1'b0;
        foreach (r.v[i]) r.v[i] = '0;
        if (md[0] != 0) begin
          r.v[0] = scale_val(longint'(pts[k].fx) - mean[0], md[0]);
          r.v[1] = scale_val(longint'(pts[k].fy) - mean[1], md[0]);
          r.v[4] = scale_val(longint'(pts[k].s1), md[0]);
        end
        if (md[1] != 0) begin
          r.v[2] = scale_val(longint'(pts[k].sx) - mean[2], md[1]);
          r.v[3] = scale_val(longint'(pts[k].sy) - mean[3], md[1]);
          r.v[5] = scale_val(longint'(pts[k].s2), md[1]);
        end
        pending.push_back(r);
      end
      r.kind = pmn_pkg::KIND_STATS;
      r.last = 1'b1;
      foreach (mean[i]) r.v[i] = 32'(mean[i]);
      r.v[4] = md[0] > 64'h7fff_ffff ? 32'h7fff_ffff : md[0][31:0];
      r.v[5] = md[1] > 64'h7fff_ffff ? 32'h7fff_ffff : md[1][31:0];
      pending.push_back(r);
      cnt = 0;
      foreach (csum[i]) csum[i] = 0;
    endfunction

    function void check(norm_t got);
      norm_t e;
      logic  bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction kind=%0b", got.kind);
        return;
      end
      e = pending.pop_front();
      bad = (got.kind !== e.kind) || (got.last !== e.last);
      foreach (e.v[i]) if (got.v[i] !== e.v[i]) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp kind=%0b v=%h %h %h %h %h %h last=%0b",
                    " / got kind=%0b v=%h %h %h %h %h %h last=%0b"},
                   e.kind, e.v[0], e.v[1], e.v[2], e.v[3], e.v[4], e.v[5], e.last,
                   got.kind, got.v[0], got.v[1], got.v[2], got.v[3], got.v[4],
                   got.v[5], got.last);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_first_x, in_first_y, in_second_x, in_second_y;
  logic        [30:0] in_first_sigma, in_second_sigma;
  logic               in_last_in;
  logic               out_strobe, out_kind, out_last_out;
  logic signed [31:0] out_v0, out_v1, out_v2, out_v3, out_v4, out_v5;

  norm_scoreboard sb;
  int             cycles;

  point_match_normalizer u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_first_sigma(in_first_sigma), .in_second_sigma(in_second_sigma),
    .in_last_in(in_last_in),
    .out_strobe(out_strobe), .out_kind(out_kind),
    .out_v0(out_v0), .out_v1(out_v1), .out_v2(out_v2),
    .out_v3(out_v3), .out_v4(out_v4), .out_v5(out_v5),
    .out_last_out(out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result monitor: values are read right after the edge, i.e. pre-edge state
  always @(posedge clk) begin
    norm_t got;
    if (rst_n && out_strobe) begin
      got.kind = out_kind;
      got.last = out_last_out;
      got.v[0] = out_v0;
      got.v[1] = out_v1;
      got.v[2] = out_v2;
      got.v[3] = out_v3;
      got.v[4] = out_v4;
      got.v[5] = out_v5;
      sb.check(got);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("point_match_normalizer regression: fail");
      $finish;
    end
  end

  // Present one transaction from the falling edge; hold until accepted
  task automatic send(corr_t c);
    logic taken;
    @(negedge clk);
    in_first_x      <= c.fx;
    in_first_y      <= c.fy;
    in_second_x     <= c.sx;
    in_second_y     <= c.sy;
    in_first_sigma  <= c.s1;
    in_second_sigma <= c.s2;
    in_last_in      <= c.last;
    start           <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    sb.note(c);
  endtask

  // Drop start for a given gap (sender burst boundary)
  task automatic idle_gap(int cyc);
    @(negedge clk);
    start <= 1'b0;
    repeat (cyc) @(negedge clk);
  endtask

  function automatic corr_t mk(int fx, int fy, int sx, int sy, int s1, int s2,
                               bit last);
    corr_t c;
    c.fx = fx; c.fy = fy; c.sx = sx; c.sy = sy;
    c.s1 = s1[30:0]; c.s2 = s2[30:0]; c.last = last;
    return c;
  endfunction

  // Coordinate: full range, or a small spread around a per-run center
  function automatic logic [31:0] rnd_coord(int mode, logic [31:0] center);
    case (mode)
      0: return $urandom;
      1: return center + $urandom_range(0, 2047) - 1024;
      default: return center + $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  initial begin
    corr_t       c;
    int          burst, len, mode, sent;
    logic [31:0] c1, c2;

    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_first_x = '0; in_first_y = '0; in_second_x = '0; in_second_y = '0;
    in_first_sigma = '0; in_second_sigma = '0; in_last_in = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // lone point: zero mean distance in both images
    send(mk(32'h7fff_ffff, 32'h8000_0000, 0, -1, 32'h7fff_ffff, 0, 1));
    // extremes of the coordinate range
    send(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            0, 32'h7fff_ffff, 0));
    send(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
            32'h7fff_ffff, 0, 1));
    idle_gap(3);
    // mean distance of one raw unit: max sigma saturates
    send(mk(0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    send(mk(2, 0, 0, 2, 32'h7fff_ffff, 32'h7fff_ffff, 1));
    // one image degenerate, the other spread out
    send(mk(100, 100, -65536, 65536, 65536, 65536, 0));
    send(mk(100, 100, 65536, -65536, 1, 2, 0));
    send(mk(100, 100, 3, 5, 32'h7fff_ffff, 0, 1));
    // negative means, and a mean that truncates
    send(mk(-3, -5, -7, 1, 7, 9, 0));
    send(mk(0, 0, 0, 0, 11, 13, 0));
    send(mk(0, -1, 1, 0, 0, 0, 1));
    idle_gap(2);

    // --- random ---
    sent = 0;
    while (sent < RAND_ITEMS) begin
      mode = $urandom_range(0, 2);
      c1 = $urandom;
      c2 = $urandom;
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(MAXP - 1, MAXP + 3);  // around capacity
        1, 2:    len = $urandom_range(7, 20);
        default: len = $urandom_range(1, 6);
      endcase
      burst = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        c.fx = rnd_coord(mode, c1);
        c.fy = rnd_coord(mode, c1 ^ 32'h5a5a_0000);
        c.sx = rnd_coord(mode, c2);
        c.sy = rnd_coord(mode, c2 ^ 32'h0000_a5a5);
        c.s1 = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
        c.s2 = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
        c.last = (k == len - 1);
        send(c);
        if (k < MAXP) sent++;
        if (--burst == 0) begin
          idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
          burst = $urandom_range(1, 6);
        end
      end
      if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 20));
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("point_match_normalizer regression: pass");
    end else begin
      $display("point_match_normalizer regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pmn_pkg.sv
sv/pmn_arith.sv
sv/point_match_normalizer.sv
sv/pmn_checker.sv
tb/tb.sv
